>>> src/ls2_pkg.sv
// ----------------------------------------------------------------------------
// ls2_pkg: shared types and constants for the 2x2 linear solver
// Holds the field widths, the fraction-bit count and the beat types.
// ----------------------------------------------------------------------------
package ls2_pkg;

  localparam int unsigned DataW    = 32;
  localparam int unsigned FracBits = 16;
  localparam int unsigned ProdW    = 2 * DataW;      // one full product
  localparam int unsigned WideW    = ProdW + 1;      // difference of two products
  localparam int unsigned MagW     = ProdW;          // magnitude of a difference
  // The quotient holds at most 34 bits once capped, so the divider only needs
  // to produce the low QuotW bits; larger values clip to the cap.
  localparam int unsigned QuotW    = 34;
  localparam int unsigned DivSteps = MagW + FracBits; // dividend bits, fraction included

  typedef struct packed {
    logic signed [DataW-1:0] mat_r0c0;
    logic signed [DataW-1:0] mat_r0c1;
    logic signed [DataW-1:0] mat_r1c0;
    logic signed [DataW-1:0] mat_r1c1;
    logic signed [DataW-1:0] rhs_first;
    logic signed [DataW-1:0] rhs_second;
  } in_beat_t;

  typedef struct packed {
    logic signed [DataW-1:0] sol_first;
    logic signed [DataW-1:0] sol_second;
    logic                    singular;
    logic                    saturated;
  } out_beat_t;

  // Operands of one division, carried down the divider pipeline.
  typedef struct packed {
    logic [MagW-1:0] num_mag;
    logic [MagW-1:0] den_mag;
    logic            neg;
  } div_op_t;

endpackage

>>> src/ls2_if.sv
// ----------------------------------------------------------------------------
// ls2_in_if / ls2_out_if: valid-ready channels of the 2x2 linear solver
// One beat moves when valid and ready are both high at a rising edge.
// ----------------------------------------------------------------------------
interface ls2_in_if;
  logic              valid;
  logic              ready;
  ls2_pkg::in_beat_t data;
  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

interface ls2_out_if;
  logic               valid;
  logic               ready;
  ls2_pkg::out_beat_t data;
  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

>>> src/ls2_mul.sv
// ----------------------------------------------------------------------------
// ls2_mul: product and difference stages
// Stage 1 forms the six 32x32 products, stage 2 forms det, n0 and n1 and
// turns each into sign and magnitude for the dividers.
// ----------------------------------------------------------------------------
module ls2_mul (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 en_i,
  input  logic                 valid_i,
  input  ls2_pkg::in_beat_t    data_i,
  output logic                 valid_o,
  output ls2_pkg::div_op_t     op0_o,
  output ls2_pkg::div_op_t     op1_o,
  output logic                 singular_o
);

  localparam int unsigned PW = ls2_pkg::ProdW;
  localparam int unsigned WW = ls2_pkg::WideW;

  logic signed [PW-1:0] ad_q, bc_q, de_q, bf_q, af_q, ce_q;
  logic                 v1_q, v2_q;
  logic signed [WW-1:0] det_w, n0_w, n1_w;
  logic [PW-1:0]        detm_w, n0m_w, n1m_w;
  ls2_pkg::div_op_t     op0_q, op1_q;
  logic                 sing_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
    end else if (en_i) begin
      v1_q <= valid_i;
      v2_q <= v1_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      ad_q <= data_i.mat_r0c0 * data_i.mat_r1c1;
      bc_q <= data_i.mat_r0c1 * data_i.mat_r1c0;
      de_q <= data_i.mat_r1c1 * data_i.rhs_first;
      bf_q <= data_i.mat_r0c1 * data_i.rhs_second;
      af_q <= data_i.mat_r0c0 * data_i.rhs_second;
      ce_q <= data_i.mat_r1c0 * data_i.rhs_first;
    end
  end

  function automatic logic [PW-1:0] mag(input logic signed [WW-1:0] v);
    logic [WW-1:0] u;
    u = v[WW-1] ? (~v + 1'b1) : v;
    return u[PW-1:0];
  endfunction

  always_comb begin
    det_w  = WW'(ad_q) - WW'(bc_q);
    n0_w   = WW'(de_q) - WW'(bf_q);
    n1_w   = WW'(af_q) - WW'(ce_q);
    detm_w = mag(det_w);
    n0m_w  = mag(n0_w);
    n1m_w  = mag(n1_w);
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      op0_q  <= '{num_mag: n0m_w, den_mag: detm_w,
                  neg: (n0_w[WW-1] != det_w[WW-1]) && (n0_w != '0)};
      op1_q  <= '{num_mag: n1m_w, den_mag: detm_w,
                  neg: (n1_w[WW-1] != det_w[WW-1]) && (n1_w != '0)};
      sing_q <= (det_w == '0);
    end
  end

  assign valid_o    = v2_q;
  assign op0_o      = op0_q;
  assign op1_o      = op1_q;
  assign singular_o = sing_q;

endmodule

>>> src/ls2_div.sv
// ----------------------------------------------------------------------------
// ls2_div: pipelined restoring divider
// One quotient bit per stage; each stage holds remainder, quotient and
// operands. The quotient is capped as it grows so that it stays narrow.
// ----------------------------------------------------------------------------
module ls2_div (
  input  logic                       clk_i,
  input  logic                       en_i,
  input  ls2_pkg::div_op_t           op_i,
  output logic [ls2_pkg::QuotW-1:0]  quot_o,
  output logic                       neg_o
);

  localparam int unsigned N  = ls2_pkg::DivSteps;
  localparam int unsigned MW = ls2_pkg::MagW;
  localparam int unsigned QW = ls2_pkg::QuotW;
  localparam int unsigned RW = MW + 1;
  localparam logic [QW-1:0] QCap = QW'(1) << (QW - 1);

  logic [RW-1:0] rem_q  [N+1];
  logic [QW-1:0] quo_q  [N+1];
  logic [MW-1:0] num_q  [N+1];
  logic [MW-1:0] den_q  [N+1];
  logic          neg_q  [N+1];

  always_comb begin
    rem_q[0] = '0;
    quo_q[0] = '0;
    num_q[0] = op_i.num_mag;
    den_q[0] = op_i.den_mag;
    neg_q[0] = op_i.neg;
  end

  for (genvar s = 0; s < N; s++) begin : g_stage
    // Dividend bit for step index i = N-1-s; fraction positions shift in zero.
    localparam int I = N - 1 - s;
    logic          bit_w;
    logic [RW-1:0] sh_w;
    logic          ge_w;
    logic [QW:0]   qn_w;
    always_comb begin
      bit_w = (I >= int'(ls2_pkg::FracBits)) ?
              num_q[s][(I >= int'(ls2_pkg::FracBits)) ? I - ls2_pkg::FracBits : 0] : 1'b0;
      sh_w  = {rem_q[s][RW-2:0], bit_w};
      ge_w  = (sh_w >= RW'(den_q[s]));
      qn_w  = {quo_q[s], ge_w};
      if (qn_w > (QW+1)'(QCap)) qn_w = (QW+1)'(QCap);
    end
    always_ff @(posedge clk_i) begin
      if (en_i) begin
        rem_q[s+1] <= ge_w ? (sh_w - RW'(den_q[s])) : sh_w;
        quo_q[s+1] <= qn_w[QW-1:0];
        num_q[s+1] <= num_q[s];
        den_q[s+1] <= den_q[s];
        neg_q[s+1] <= neg_q[s];
      end
    end
  end

  assign quot_o = quo_q[N];
  assign neg_o  = neg_q[N];

endmodule

>>> src/linear_solve_2x2_unit.sv
// ----------------------------------------------------------------------------
// linear_solve_2x2_unit: Cramer's-rule solver for 2x2 systems in Q16.16
// Solves M*x = v per beat with exact products and pipelined division.
// ----------------------------------------------------------------------------
// Usage:
//   in_if carries one system per beat: the four matrix entries and the two
//   right-hand elements, all signed Q16.16. out_if returns the two solution
//   elements, truncated toward zero and clipped to 32 bits, with a singular
//   flag (determinant exactly zero, both solutions zero) and a saturated flag.
//   Throughput is one beat per cycle while out_if is not stalled. Two
//   stages form the products and the determinant and numerators, eighty
//   divider stages each give one quotient bit (64 numerator bits plus the
//   sixteen fraction bits), and one output register applies sign and clipping.
//   The whole pipeline advances only when the output register is empty or
//   being taken, so a stalled receiver freezes every stage and in_if.ready
//   falls; nothing is lost or repeated. Reset clears the valid bits only;
//   the block keeps no other state.
// ----------------------------------------------------------------------------
module linear_solve_2x2_unit (
  input  logic      clk_i,
  input  logic      rst_ni,
  ls2_in_if.sink    in_if,
  ls2_out_if.source out_if
);

  localparam int unsigned DW   = ls2_pkg::DataW;
  localparam int unsigned QW   = ls2_pkg::QuotW;
  localparam int unsigned DLen = ls2_pkg::DivSteps;

  logic             en_w;
  logic             mv_w, ms_w;
  ls2_pkg::div_op_t op0_w, op1_w;
  logic [QW-1:0]    q0_w, q1_w;
  logic             ng0_w, ng1_w;
  logic             dv_q [DLen+1];
  logic             ds_q [DLen+1];
  logic             ov_q;
  ls2_pkg::out_beat_t ob_q;

  // Single enable: the pipeline moves when the output slot is free or leaving.
  assign en_w        = !ov_q || out_if.ready;
  assign in_if.ready = en_w;

  ls2_mul u_mul (
    .clk_i, .rst_ni, .en_i(en_w), .valid_i(in_if.valid), .data_i(in_if.data),
    .valid_o(mv_w), .op0_o(op0_w), .op1_o(op1_w), .singular_o(ms_w)
  );

  ls2_div u_div0 (.clk_i, .en_i(en_w), .op_i(op0_w), .quot_o(q0_w), .neg_o(ng0_w));
  ls2_div u_div1 (.clk_i, .en_i(en_w), .op_i(op1_w), .quot_o(q1_w), .neg_o(ng1_w));

  // Valid and singular flags travel alongside the divider stages.
  always_comb begin
    dv_q[0] = mv_w;
    ds_q[0] = ms_w;
  end
  for (genvar s = 0; s < DLen; s++) begin : g_tag
    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        dv_q[s+1] <= 1'b0;
      end else if (en_w) begin
        dv_q[s+1] <= dv_q[s];
      end
    end
    always_ff @(posedge clk_i) begin
      if (en_w) ds_q[s+1] <= ds_q[s];
    end
  end

  // Sign and clip: positive results top out at 2^31-1, negative at -2^31.
  function automatic logic [DW:0] fin(input logic [QW-1:0] q, input logic ng);
    logic [QW-1:0] lim;
    logic [QW-1:0] neg_q;
    lim = ng ? (QW'(1) << (DW - 1)) : ((QW'(1) << (DW - 1)) - 1'b1);
    if (q > lim) return {1'b1, lim[DW-1:0]};
    neg_q = ~q + 1'b1;
    return {1'b0, ng ? neg_q[DW-1:0] : q[DW-1:0]};
  endfunction

  logic [DW:0] f0_w, f1_w;
  assign f0_w = fin(q0_w, ng0_w);
  assign f1_w = fin(q1_w, ng1_w);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ov_q <= 1'b0;
    end else if (en_w) begin
      ov_q <= dv_q[DLen];
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_w) begin
      if (ds_q[DLen]) begin
        ob_q <= '{sol_first: '0, sol_second: '0, singular: 1'b1, saturated: 1'b0};
      end else begin
        ob_q <= '{sol_first: f0_w[DW-1:0], sol_second: f1_w[DW-1:0],
                  singular: 1'b0, saturated: f0_w[DW] | f1_w[DW]};
      end
    end
  end

  assign out_if.valid = ov_q;
  assign out_if.data  = ob_q;

  // A waiting beat is held until taken.
  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ov_q && !out_if.ready |=> ov_q && $stable(ob_q))
    else $error("output beat changed while stalled");

  // A singular result never reports saturation and carries zero solutions.
  a_sing: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ov_q && ob_q.singular |-> !ob_q.saturated && ob_q.sol_first == '0 &&
      ob_q.sol_second == '0)
    else $error("singular beat with nonzero payload");

  // Input is refused only while the output register is full and stalled.
  a_ready: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !in_if.ready |-> ov_q && !out_if.ready)
    else $error("input refused without a stall");

endmodule
